// File: src/lpe_pkg.sv
package lpe_pkg;

    // Field widths of the input and result words.
    localparam int X_W   = 32;
    localparam int DEG_W = 8;
    localparam int N_W   = DEG_W - 1;

    // Fixed-point format and degree limit.
    localparam int FRAC_BITS  = 30;
    localparam int MAX_DEGREE = 127;

    // Internal widths: full product, recurrence numerator, divider dividend.
    localparam int PROD_W     = 2 * X_W;
    localparam int NUM_W      = 41;
    localparam int DIV_BITS   = 8;
    localparam int DVD_W      = 40;
    localparam int DIV_ROUNDS = DVD_W / DIV_BITS;
    localparam int RND_W      = $clog2(DIV_ROUNDS);

    localparam logic signed [X_W-1:0] FX_ONE = X_W'(64'd1 << FRAC_BITS);
    localparam logic [N_W-1:0]        N_MAX  = N_W'(MAX_DEGREE);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic num;
        logic div;
        logic upd;
    } lpe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic special;
        logic last_step;
    } lpe_stat_t;

endpackage

// File: src/legendre_poly_eval_core.sv
// Channel  Handshake          Word fields
// s_       s_valid / s_ready  s_arg_x (32, signed Q1.30), s_degree (8, signed)
// m_       m_valid / m_ready  m_value (32, signed Q1.30)
//
// One word is in flight at a time: s_ready drops at acceptance and returns the
// cycle after the result is taken. Closed forms (negative degree, x at plus or
// minus one, degree zero or one) raise m_valid from the CHECK state after
// acceptance; otherwise m_valid rises after the last recurrence step, each step taking a
// multiply, a numerator, five divider rounds of eight quotient bits and an
// update. Reset is synchronous, active low, and clears the controller.
module legendre_poly_eval_core
    import lpe_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [X_W-1:0]   s_arg_x,
    input  logic signed [DEG_W-1:0] s_degree,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [X_W-1:0]   m_value
);

    lpe_cmd_t  cmd;
    lpe_stat_t stat;

    // Sequencer.
    lpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and operand registers.
    lpe_datapath u_datapath (
        .aclk     (aclk),
        .s_arg_x  (s_arg_x),
        .s_degree (s_degree),
        .cmd      (cmd),
        .stat     (stat),
        .m_value  (m_value)
    );

endmodule

// File: src/lpe_ctrl.sv
module lpe_ctrl
    import lpe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  lpe_stat_t stat,
    output lpe_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_NUM,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic             s_ready_reg;
    logic             m_valid_reg;
    logic [RND_W-1:0] rnd_reg;

    // Sequencer: one recurrence step is MUL, NUM, the divider rounds and UPD.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_CHECK;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_CHECK: begin
                    if (stat.special) begin
                        state_reg   <= ST_DONE;
                        m_valid_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    state_reg <= ST_DIV;
                    rnd_reg   <= '0;
                end
                ST_DIV: begin
                    if (rnd_reg == RND_W'(DIV_ROUNDS - 1)) begin
                        state_reg <= ST_UPD;
                    end else begin
                        rnd_reg <= rnd_reg + RND_W'(1);
                    end
                end
                ST_UPD: begin
                    if (stat.last_step) begin
                        state_reg   <= ST_DONE;
                        m_valid_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (m_ready) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath commands follow the state.
    always_comb begin
        cmd.load = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.mul  = (state_reg == ST_MUL);
        cmd.num  = (state_reg == ST_NUM);
        cmd.div  = (state_reg == ST_DIV);
        cmd.upd  = (state_reg == ST_UPD);
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// File: src/lpe_datapath.sv
module lpe_datapath
    import lpe_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [X_W-1:0]   s_arg_x,
    input  logic signed [DEG_W-1:0] s_degree,
    input  lpe_cmd_t                cmd,
    output lpe_stat_t               stat,
    output logic signed [X_W-1:0]   m_value
);

    logic signed [X_W-1:0]    x_reg, p0_reg, p1_reg, res_reg;
    logic [N_W-1:0]           n_reg, k_reg;
    logic                     special_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NUM_W-1:0]  pk_reg;
    logic                     neg_reg;
    logic [DVD_W-1:0]         dvd_reg, quo_reg;
    logic [N_W-1:0]           rem_reg;

    // Argument clamp, degree limit and the closed-form cases.
    logic signed [X_W-1:0] x_c;
    logic [N_W-1:0]        n_c;
    logic signed [X_W-1:0] sp_value;
    logic                  sp_hit;

    always_comb begin
        if (s_arg_x > FX_ONE) begin
            x_c = FX_ONE;
        end else if (s_arg_x < -FX_ONE) begin
            x_c = -FX_ONE;
        end else begin
            x_c = s_arg_x;
        end
        if (s_degree[DEG_W-1]) begin
            n_c = '0;
        end else if (s_degree[N_W-1:0] > N_MAX) begin
            n_c = N_MAX;
        end else begin
            n_c = s_degree[N_W-1:0];
        end
        sp_hit   = 1'b1;
        sp_value = FX_ONE;
        if (s_degree[DEG_W-1]) begin
            sp_value = '0;
        end else if (x_c == FX_ONE) begin
            sp_value = FX_ONE;
        end else if (x_c == -FX_ONE) begin
            sp_value = n_c[0] ? -FX_ONE : FX_ONE;
        end else if (n_c == '0) begin
            sp_value = FX_ONE;
        end else if (n_c == N_W'(1)) begin
            sp_value = x_c;
        end else begin
            sp_hit = 1'b0;
        end
    end

    // Numerator of one step: (2k+1)*floor(x*P1 / one) - k*P0.
    logic signed [X_W-1:0]   t_val;
    logic signed [NUM_W-1:0] num_val;
    logic [DVD_W-1:0]        num_mag;

    always_comb begin
        t_val   = $signed(prod_reg[FRAC_BITS+X_W-1:FRAC_BITS]);
        num_val = NUM_W'(t_val) * NUM_W'($signed({1'b0, k_reg, 1'b1})) - pk_reg;
        if (num_val[NUM_W-1]) begin
            num_mag = DVD_W'(-num_val);
        end else begin
            num_mag = DVD_W'(num_val);
        end
    end

    // One divider round: eight restoring steps by the divisor k+1.
    logic [N_W-1:0]      dsr;
    logic [N_W-1:0]      rem_step;
    logic [N_W:0]        trial;
    logic [DIV_BITS-1:0] qbits;

    always_comb begin
        dsr      = k_reg + N_W'(1);
        rem_step = rem_reg;
        trial    = '0;
        qbits    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem_step, dvd_reg[DVD_W-1-i]};
            if (trial >= {1'b0, dsr}) begin
                trial                 = trial - {1'b0, dsr};
                qbits[DIV_BITS-1-i]   = 1'b1;
            end
            rem_step = trial[N_W-1:0];
        end
    end

    // Clamp the quotient to one and restore the sign.
    logic signed [X_W-1:0] q_mag, p_new;

    always_comb begin
        if (quo_reg > DVD_W'(FX_ONE)) begin
            q_mag = FX_ONE;
        end else begin
            q_mag = quo_reg[X_W-1:0];
        end
        p_new = neg_reg ? -q_mag : q_mag;
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg       <= x_c;
            n_reg       <= n_c;
            k_reg       <= N_W'(1);
            p0_reg      <= FX_ONE;
            p1_reg      <= x_c;
            special_reg <= sp_hit;
            res_reg     <= sp_value;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'(p1_reg);
            pk_reg   <= NUM_W'(p0_reg) * NUM_W'($signed({1'b0, k_reg}));
        end
        if (cmd.num) begin
            neg_reg <= num_val[NUM_W-1];
            dvd_reg <= num_mag;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (cmd.div) begin
            dvd_reg <= {dvd_reg[DVD_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DVD_W-DIV_BITS-1:0], qbits};
        end
        if (cmd.upd) begin
            p0_reg  <= p1_reg;
            p1_reg  <= p_new;
            res_reg <= p_new;
            k_reg   <= k_reg + N_W'(1);
        end
    end

    assign stat.special   = special_reg;
    assign stat.last_step = (k_reg + N_W'(1)) == n_reg;
    assign m_value        = res_reg;

endmodule
